>>> design/ptlm_pkg.sv
// Package with shared types, constants and the CORDIC arctangent table.
`default_nettype none
package ptlm_pkg;
   localparam int AtanEntries = 30;
   localparam logic [31:0] CordicKQ30 = 32'd652032874;
   localparam logic [31:0] HalfTurn32 = 32'h8000_0000;
   localparam logic [31:0] QuarterTurn32 = 32'h4000_0000;
   localparam logic [15:0] QuarterTurn16 = 16'd16384;
   localparam logic [2:0] LabelNone = 3'd7;
   localparam logic [7:0] MaskReset = 8'd127;
   localparam logic CmdStore = 1'b0;
   localparam logic CmdPose = 1'b1;

   // One queued pose job.
   typedef struct packed {
      logic [2:0]         label;
      logic [15:0]        range_dist;
      logic [15:0]        bearing;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } job_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0: v = 32'd536870912;   5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;   5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;    5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;    5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;     5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;     5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;     5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;      5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;      5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;       5'd19: v = 32'd1304;
         5'd20: v = 32'd652;        5'd21: v = 32'd326;
         5'd22: v = 32'd163;        5'd23: v = 32'd81;
         5'd24: v = 32'd41;         5'd25: v = 32'd20;
         5'd26: v = 32'd10;         5'd27: v = 32'd5;
         5'd28: v = 32'd3;          5'd29: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

>>> design/ptlm_front.sv
// Front end: stores detections, filters pose items by the label mask, fills a job queue.
`default_nettype none
module ptlm_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_cmd,
   input  wire logic [2:0]          req_label,
   input  wire logic [15:0]         req_range_dist,
   input  wire logic [15:0]         req_bearing,
   input  wire logic [31:0]         req_pos_x,
   input  wire logic [31:0]         req_pos_y,
   input  wire logic [15:0]         req_quat_w,
   input  wire logic [15:0]         req_quat_x,
   input  wire logic [15:0]         req_quat_y,
   input  wire logic [15:0]         req_quat_z,
   input  wire logic [7:0]          mask,
   output logic                     job_valid,
   input  wire logic                job_ready,
   output ptlm_pkg::job_type        job
);
   import ptlm_pkg::*;

   logic [2:0]  label_ff, label_in;
   logic [15:0] range_ff, range_in, bear_ff, bear_in;
   job_type     q_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        acc, push, pop;
   job_type     nj;

   assign req_ready = (cnt_ff != 2'd2);
   assign acc = req_valid && req_ready;
   assign push = acc && (req_cmd == CmdPose) && mask[label_ff];
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_ready;
   assign job = q_ff[rp_ff];

   always_comb begin
      nj.label = label_ff; nj.range_dist = range_ff; nj.bearing = bear_ff;
      nj.pos_x = req_pos_x; nj.pos_y = req_pos_y;
      nj.quat_w = req_quat_w; nj.quat_x = req_quat_x;
      nj.quat_y = req_quat_y; nj.quat_z = req_quat_z;
      label_in = label_ff; range_in = range_ff; bear_in = bear_ff;
      if (acc && req_cmd == CmdStore) begin
         label_in = req_label; range_in = req_range_dist; bear_in = req_bearing;
      end
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_ff <= LabelNone; range_ff <= '0; bear_ff <= '0;
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         label_ff <= label_in; range_ff <= range_in; bear_ff <= bear_in;
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= nj;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !req_ready) else $error("ready while full");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !job_valid) else $error("job from empty queue");
endmodule
`default_nettype wire

>>> design/ptlm_back.sv
// Back end: yaw by vectoring CORDIC, rotation CORDIC, scaling, offset and saturation.
`default_nettype none
module ptlm_back #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               job_valid,
   output logic                    job_ready,
   input  wire ptlm_pkg::job_type  job,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_out_label,
   output logic [31:0]             rsp_map_x,
   output logic [31:0]             rsp_map_y
);
   import ptlm_pkg::*;

   localparam int Steps = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
   localparam logic [4:0] LastStep = 5'(Steps - 1);

   localparam logic [2:0] StIdle = 3'd0, StMul = 3'd1, StPre = 3'd2, StVec = 3'd3,
                          StRotPre = 3'd4, StRot = 3'd5, StScale = 3'd6, StOut = 3'd7;

   logic [2:0]  st_ff, st_in;
   job_type     j_ff;
   logic [4:0]  i_ff;
   logic signed [32:0] p1_ff, p2_ff, p3_ff, p4_ff;   // w*z, x*y, y*y, z*z
   logic signed [35:0] x_ff, y_ff, x_in, y_in;
   logic [31:0] acc_ff, acc_in;
   logic signed [32:0] a_ff, a_in;
   logic        flip_ff;
   logic signed [48:0] mx_ff, my_ff;
   logic        ov_ff;
   logic [2:0]  ol_ff;
   logic [31:0] ox_ff, oy_ff;
   logic signed [35:0] s_v, c_v, sx, sy;
   logic [31:0] at;
   logic [15:0] yaw16, theta;
   logic [31:0] ang, ang_q, ang_h;
   logic        rflip;
   logic        load_out;
   logic signed [33:0] sumx, sumy;

   function automatic logic [31:0] sat(input logic signed [33:0] v);
      if (v > 34'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -34'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   assign job_ready = (st_ff == StIdle);
   assign rsp_valid = ov_ff;
   assign rsp_out_label = ol_ff;
   assign rsp_map_x = ox_ff;
   assign rsp_map_y = oy_ff;
   assign load_out = (st_ff == StOut) && (!ov_ff || rsp_ready);

   always_comb begin
      at = atan_entry(i_ff);
      sx = x_ff >>> i_ff;
      sy = y_ff >>> i_ff;
      s_v = 36'(p1_ff + p2_ff) <<< 1;
      c_v = (36'sd1 <<< 28) - (36'(p3_ff + p4_ff) <<< 1);
      yaw16 = 16'((acc_ff + 32'h8000) >> 16);
      theta = j_ff.bearing + yaw16 - QuarterTurn16;
      ang = {theta, 16'h0000};
      ang_q = ang + QuarterTurn32;
      ang_h = ang + HalfTurn32;
      rflip = ang_q[31];
      sumx = 34'(j_ff.pos_x) + 34'(mx_ff >>> 30);
      sumy = 34'(j_ff.pos_y) + 34'(my_ff >>> 30);
      x_in = x_ff; y_in = y_ff; acc_in = acc_ff; a_in = a_ff;
      if (st_ff == StPre) begin
         if (c_v[35]) begin
            x_in = -c_v; y_in = -s_v; acc_in = HalfTurn32;
         end else begin
            x_in = c_v; y_in = s_v; acc_in = '0;
         end
      end else if (st_ff == StVec) begin
         if (!y_ff[35]) begin
            x_in = x_ff + sy; y_in = y_ff - sx; acc_in = acc_ff + at;
         end else begin
            x_in = x_ff - sy; y_in = y_ff + sx; acc_in = acc_ff - at;
         end
      end else if (st_ff == StRotPre) begin
         x_in = 36'(CordicKQ30); y_in = '0;
         a_in = rflip ? {ang_h[31], ang_h} : {ang[31], ang};
      end else if (st_ff == StRot) begin
         if (!a_ff[32]) begin
            x_in = x_ff - sy; y_in = y_ff + sx; a_in = a_ff - 33'(at);
         end else begin
            x_in = x_ff + sy; y_in = y_ff - sx; a_in = a_ff + 33'(at);
         end
      end
      st_in = st_ff;
      case (st_ff)
         StIdle:   if (job_valid) st_in = StMul;
         // Zero yaw vector: the vectoring pass is skipped, leaving a zero angle.
         StPre:    st_in = (c_v == '0 && s_v == '0) ? StRotPre : StVec;
         StMul:    st_in = StPre;
         StVec:    if (i_ff == LastStep) st_in = StRotPre;
         StRotPre: st_in = StRot;
         StRot:    if (i_ff == LastStep) st_in = StScale;
         StScale:  st_in = StOut;
         StOut:    if (!ov_ff || rsp_ready) st_in = StIdle;
         default:  st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= load_out || (ov_ff && !rsp_ready);
      end
      x_ff <= x_in; y_ff <= y_in; acc_ff <= acc_in; a_ff <= a_in;
      if (st_ff == StVec || st_ff == StRot) i_ff <= i_ff + 5'd1;
      case (st_ff)
         StIdle: if (job_valid) j_ff <= job;
         StMul: begin
            p1_ff <= 33'(j_ff.quat_w * j_ff.quat_z);
            p2_ff <= 33'(j_ff.quat_x * j_ff.quat_y);
            p3_ff <= 33'(j_ff.quat_y * j_ff.quat_y);
            p4_ff <= 33'(j_ff.quat_z * j_ff.quat_z);
         end
         StPre: i_ff <= '0;
         StRotPre: begin
            i_ff <= '0;
            flip_ff <= rflip;
         end
         StScale: begin
            mx_ff <= 49'($signed({1'b0, j_ff.range_dist}) * (flip_ff ? -x_ff : x_ff))
                     + (49'sd1 <<< 29);
            my_ff <= 49'($signed({1'b0, j_ff.range_dist}) * (flip_ff ? -y_ff : y_ff))
                     + (49'sd1 <<< 29);
         end
         StOut: if (!ov_ff || rsp_ready) begin
            ol_ff <= j_ff.label; ox_ff <= sat(sumx); oy_ff <= sat(sumy);
         end
         default: ;
      endcase
   end

   a_idle: assert property (@(posedge clock) disable iff (reset)
      (st_ff == StIdle && job_valid) |=> st_ff == StMul) else $error("job not taken");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_map_x))
      else $error("result lost");
   a_step: assert property (@(posedge clock) disable iff (reset)
      (st_ff == StVec || st_ff == StRot) |-> i_ff <= LastStep) else $error("step overrun");
endmodule
`default_nettype wire

>>> design/polar_to_local_mapper_core.sv
// Top level of the polar detection to local frame mapper.
//  channel | ports              | role
//  req     | req_valid/ready    | detection or pose transaction in
//  rsp     | rsp_valid/ready    | mapped detection out
//  csr     | APB, address 0     | valid_label_mask
// A detection transaction is stored in the front and gives no result.
// A pose transaction whose stored label passes the mask runs in the back end through the two
// passes of the shared CORDIC iteration (steps capped at 30); a zero yaw vector skips the
// vectoring pass. The front queue holds two jobs.
// Reset is synchronous: mask 127, stored label 7, range and bearing zero.
// A stalled result holds in the output register; the front keeps accepting until the queue is full.
`default_nettype none
module polar_to_local_mapper_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_cmd,
   input  wire logic [2:0]  req_label,
   input  wire logic [15:0] req_range_dist,
   input  wire logic [15:0] req_bearing,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [15:0] req_quat_w,
   input  wire logic [15:0] req_quat_x,
   input  wire logic [15:0] req_quat_y,
   input  wire logic [15:0] req_quat_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_out_label,
   output logic [31:0]      rsp_map_x,
   output logic [31:0]      rsp_map_y,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [0:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import ptlm_pkg::*;

   logic [7:0] mask_ff;
   logic       jv, jr;
   job_type    jb;

   assign csr_pready = 1'b1;
   assign csr_prdata = {24'd0, mask_ff};

   always_ff @(posedge clock) begin
      if (reset) mask_ff <= MaskReset;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 1'b0)
         mask_ff <= csr_pwdata[7:0];
   end

   ptlm_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .req_label, .req_range_dist,
      .req_bearing, .req_pos_x, .req_pos_y, .req_quat_w, .req_quat_x, .req_quat_y,
      .req_quat_z, .mask(mask_ff), .job_valid(jv), .job_ready(jr), .job(jb)
   );

   ptlm_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset, .job_valid(jv), .job_ready(jr), .job(jb), .rsp_valid, .rsp_ready,
      .rsp_out_label, .rsp_map_x, .rsp_map_y
   );
endmodule
`default_nettype wire
